/* rtl/pwc_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package pwc_pkg;
    localparam int MAX_IN_VERTS = 3;
    localparam int BUF_VERTS = MAX_IN_VERTS + 4;
    localparam int IDX_W = $clog2(BUF_VERTS);
    localparam int CNT_W = $clog2(BUF_VERTS + 1);
    localparam int ADDR_W = $clog2(2 * BUF_VERTS);
    localparam int VTX_W = 96;

    localparam logic [2:0] REG_CLIP_ENABLE = 3'd0;
    localparam logic [2:0] REG_MIN_X = 3'd1;
    localparam logic [2:0] REG_MAX_X = 3'd2;
    localparam logic [2:0] REG_MIN_Y = 3'd3;
    localparam logic [2:0] REG_MAX_Y = 3'd4;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_RD_A,
        ST_RD_B,
        ST_TEST,
        ST_DIV,
        ST_MUL,
        ST_WR_CROSS,
        ST_WR_B,
        ST_NEXT,
        ST_EMIT_RD,
        ST_EMIT,
        ST_EMPTY
    } state_t;

    typedef struct packed {
        logic start;
        logic [31:0] num;
        logic [31:0] den;
    } div_req_t;
endpackage
`default_nettype wire

/* rtl/polygon_window_clip.sv */
// channel   | signals                          | handshake
// ----------+----------------------------------+-------------------------
// vertex in | in_x in_y in_z in_last           | start & !busy
// result    | out_x out_y out_z out_last       | out_valid, one cycle
//           | all_clipped                      |
// config    | cfg_we cfg_index cfg_wdata       | cfg_we
// a closing vertex, with clipping enabled, runs an edge pass over the ram per
// window edge (min x, min y, max x, max y), stopping early if none is kept;
// each pass reads both ends of a segment and writes each kept vertex, with a
// bit-serial divide and a multiply per crossing; results are then read back.
// reset clears control state only; the ram needs no clearing pass.
// the receiver cannot stall.
`timescale 1ns / 1ps
`default_nettype none
module polygon_window_clip
    import pwc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [31:0] in_x,
    input  wire logic [31:0] in_y,
    input  wire logic [31:0] in_z,
    input  wire logic        in_last,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [31:0] cfg_wdata,
    output logic             out_valid,
    output logic [31:0]      out_x,
    output logic [31:0]      out_y,
    output logic [31:0]      out_z,
    output logic             out_last,
    output logic             all_clipped
);
    state_t state_reg, state_next;
    logic              clip_en_reg;
    logic signed [31:0] min_x_reg, max_x_reg, min_y_reg, max_y_reg;
    logic [IDX_W-1:0]  load_reg, load_next;
    logic [CNT_W-1:0]  vcnt_reg, vcnt_next;
    logic [CNT_W-1:0]  wcnt_reg, wcnt_next;
    logic [IDX_W-1:0]  n_reg, n_next;
    logic [1:0]        edge_reg, edge_next;
    logic              cur_reg, cur_next;
    logic [VTX_W-1:0]  a_reg, a_next, b_reg, b_next;
    logic [31:0]       t_reg;
    logic [1:0]        k_reg, k_next;
    logic [31:0]       r_reg [3];
    logic [63:0]       prod_reg;
    logic              mul_ph_reg, mul_ph_next;

    logic              we;
    logic [ADDR_W-1:0] waddr, raddr;
    logic [VTX_W-1:0]  wdata, rdata;
    div_req_t          dreq;
    logic              ddone;
    logic [30:0]       dquot;

    pwc_vram u_ram (
        .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
        .raddr(raddr), .rdata(rdata)
    );

    pwc_div u_div (
        .clk(clk), .rst_n(rst_n), .req(dreq), .done(ddone), .quot(dquot)
    );

    function automatic logic [ADDR_W-1:0] addr_of(logic bank, logic [IDX_W-1:0] i);
        addr_of = ADDR_W'(bank) * ADDR_W'(BUF_VERTS) + ADDR_W'(i);
    endfunction

    function automatic logic signed [31:0] coord(logic [VTX_W-1:0] v, logic [1:0] k);
        coord = v[32*k +: 32];
    endfunction

    logic signed [31:0] ev, ac, bc;
    logic ia, ib, axis;
    logic signed [32:0] num33, den33;
    logic [31:0] unum, uden;
    logic signed [32:0] dk;
    logic [31:0] adk;
    logic [IDX_W-1:0] n_wrap;
    logic full;
    logic [VTX_W-1:0] b_cur;

    always_comb
    begin
        axis = edge_reg[0];
        unique case (edge_reg)
            2'd0: ev = min_x_reg;
            2'd1: ev = min_y_reg;
            2'd2: ev = max_x_reg;
            default: ev = max_y_reg;
        endcase
        // second endpoint is still on the ram output during the test cycle
        b_cur = (state_reg == ST_TEST) ? rdata : b_reg;
        ac = coord(a_reg, {1'b0, axis});
        bc = coord(b_cur, {1'b0, axis});
        ia = edge_reg[1] ? (ac < ev) : (ac > ev);
        ib = edge_reg[1] ? (bc < ev) : (bc > ev);
        num33 = {ev[31], ev} - {ac[31], ac};
        den33 = {bc[31], bc} - {ac[31], ac};
        unum = num33[32] ? 32'(-num33) : num33[31:0];
        uden = den33[32] ? 32'(-den33) : den33[31:0];
        if (uden == 32'd0) uden = 32'd1;
        if (unum > uden) unum = uden;
        dk = {b_reg[32*k_reg+31], b_reg[32*k_reg +: 32]}
           - {a_reg[32*k_reg+31], a_reg[32*k_reg +: 32]};
        adk = dk[32] ? 32'(-dk) : dk[31:0];
        n_wrap = (CNT_W'(n_reg) + 1'b1 == vcnt_reg) ? '0 : IDX_W'(n_reg + 1'b1);
        full = (wcnt_reg == CNT_W'(BUF_VERTS));
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_LOAD:
                if (start && in_last)
                begin
                    if (!clip_en_reg)
                        state_next = ST_EMIT_RD;
                    else
                        state_next = ST_RD_A;
                end
            ST_RD_A:     state_next = ST_RD_B;
            ST_RD_B:     state_next = ST_TEST;
            ST_TEST:
                if (ia != ib && !full) state_next = ST_DIV;
                else if (ib && !full)  state_next = ST_WR_B;
                else                   state_next = ST_NEXT;
            ST_DIV:      if (ddone) state_next = ST_MUL;
            ST_MUL:      if (mul_ph_reg && k_reg == 2'd2) state_next = ST_WR_CROSS;
            ST_WR_CROSS: state_next = (ib && (wcnt_reg + 1'b1 != CNT_W'(BUF_VERTS)))
                                      ? ST_WR_B : ST_NEXT;
            ST_WR_B:     state_next = ST_NEXT;
            ST_NEXT:
                if (CNT_W'(n_reg) + 1'b1 < vcnt_reg) state_next = ST_RD_A;
                else if (edge_reg != 2'd3)
                    state_next = (wcnt_reg == '0) ? ST_EMPTY : ST_RD_A;
                else state_next = (wcnt_reg == '0) ? ST_EMPTY : ST_EMIT_RD;
            ST_EMIT_RD:  state_next = (vcnt_reg == '0) ? ST_EMPTY : ST_EMIT;
            ST_EMIT:     state_next = (CNT_W'(n_reg) + 1'b1 == vcnt_reg) ? ST_LOAD
                                      : ST_EMIT_RD;
            ST_EMPTY:    state_next = ST_LOAD;
            default:     state_next = ST_LOAD;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        load_next = load_reg;
        vcnt_next = vcnt_reg;
        wcnt_next = wcnt_reg;
        n_next = n_reg;
        edge_next = edge_reg;
        cur_next = cur_reg;
        a_next = a_reg;
        b_next = b_reg;
        k_next = k_reg;
        mul_ph_next = mul_ph_reg;
        we = 1'b0;
        waddr = addr_of(1'b0, load_reg);
        wdata = {in_z, in_y, in_x};
        raddr = addr_of(cur_reg, n_reg);
        dreq = '0;
        dreq.num = unum;
        dreq.den = uden;
        unique case (state_reg)
            ST_LOAD:
                if (start)
                begin
                    if (CNT_W'(load_reg) < CNT_W'(MAX_IN_VERTS))
                    begin
                        we = 1'b1;
                        load_next = load_reg + 1'b1;
                    end
                    if (in_last)
                    begin
                        vcnt_next = (CNT_W'(load_reg) < CNT_W'(MAX_IN_VERTS))
                                  ? CNT_W'(load_reg) + 1'b1 : CNT_W'(load_reg);
                        load_next = '0;
                        n_next = '0;
                        edge_next = '0;
                        cur_next = 1'b0;
                        wcnt_next = '0;
                    end
                end
            ST_RD_A:
                raddr = addr_of(cur_reg, n_reg);
            ST_RD_B:
            begin
                a_next = rdata;
                raddr = addr_of(cur_reg, n_wrap);
            end
            ST_TEST:
            begin
                b_next = rdata;
                k_next = '0;
                mul_ph_next = 1'b0;
            end
            ST_DIV:
                dreq.start = 1'b0;
            ST_MUL:
            begin
                mul_ph_next = !mul_ph_reg;
                if (mul_ph_reg) k_next = k_reg + 2'd1;
            end
            ST_WR_CROSS:
            begin
                we = 1'b1;
                waddr = addr_of(!cur_reg, IDX_W'(wcnt_reg));
                wdata = {r_reg[2], r_reg[1], r_reg[0]};
                wcnt_next = wcnt_reg + 1'b1;
            end
            ST_WR_B:
            begin
                we = 1'b1;
                waddr = addr_of(!cur_reg, IDX_W'(wcnt_reg));
                wdata = b_reg;
                wcnt_next = wcnt_reg + 1'b1;
            end
            ST_NEXT:
                if (CNT_W'(n_reg) + 1'b1 < vcnt_reg)
                    n_next = n_reg + 1'b1;
                else
                begin
                    n_next = '0;
                    vcnt_next = wcnt_reg;
                    wcnt_next = '0;
                    cur_next = !cur_reg;
                    edge_next = edge_reg + 2'd1;
                end
            ST_EMIT_RD:
                raddr = addr_of(cur_reg, n_reg);
            ST_EMIT:
                n_next = n_reg + 1'b1;
            ST_EMPTY: ;
            default: ;
        endcase
        // launch divide when leaving test toward a crossing
        if (state_reg == ST_TEST && ia != ib && !full) dreq.start = 1'b1;
    end

    // mixed-sign rounding multiply: |d| * t, rounded, added toward b
    always_ff @(posedge clk)
    begin
        if (ddone) t_reg <= {1'b0, dquot};
        if (state_reg == ST_MUL)
        begin
            if (!mul_ph_reg)
                prod_reg <= {32'd0, adk} * {32'd0, t_reg};
            else
            begin
                if (dk[32])
                    r_reg[k_reg] <= a_reg[32*k_reg +: 32]
                        - 32'((prod_reg + 64'd536870912) >> 30);
                else
                    r_reg[k_reg] <= a_reg[32*k_reg +: 32]
                        + 32'((prod_reg + 64'd536870912) >> 30);
            end
        end
        a_reg <= a_next;
        b_reg <= b_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
            clip_en_reg <= 1'b0;
            min_x_reg <= '0;
            max_x_reg <= '0;
            min_y_reg <= '0;
            max_y_reg <= '0;
            load_reg <= '0;
            vcnt_reg <= '0;
            wcnt_reg <= '0;
            n_reg <= '0;
            edge_reg <= '0;
            cur_reg <= 1'b0;
            k_reg <= '0;
            mul_ph_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            load_reg <= load_next;
            vcnt_reg <= vcnt_next;
            wcnt_reg <= wcnt_next;
            n_reg <= n_next;
            edge_reg <= edge_next;
            cur_reg <= cur_next;
            k_reg <= k_next;
            mul_ph_reg <= mul_ph_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_CLIP_ENABLE: clip_en_reg <= cfg_wdata[0];
                    REG_MIN_X:       min_x_reg <= cfg_wdata;
                    REG_MAX_X:       max_x_reg <= cfg_wdata;
                    REG_MIN_Y:       min_y_reg <= cfg_wdata;
                    REG_MAX_Y:       max_y_reg <= cfg_wdata;
                    default: ;
                endcase
            end
        end
    end

    assign busy = (state_reg != ST_LOAD);
    assign out_valid = (state_reg == ST_EMIT) || (state_reg == ST_EMPTY);
    assign out_x = (state_reg == ST_EMIT) ? rdata[31:0] : 32'd0;
    assign out_y = (state_reg == ST_EMIT) ? rdata[63:32] : 32'd0;
    assign out_z = (state_reg == ST_EMIT) ? rdata[95:64] : 32'd0;
    assign out_last = (state_reg == ST_EMPTY) ||
                      (CNT_W'(n_reg) + 1'b1 == vcnt_reg);
    assign all_clipped = (state_reg == ST_EMPTY);

`ifndef SYNTHESIS
    a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        wcnt_reg <= CNT_W'(BUF_VERTS)) else $error("write count overflow");
    a_done: assert property (@(posedge clk) disable iff (!rst_n)
        ddone |-> state_reg == ST_DIV) else $error("divide done outside divide");
    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_EMPTY |=> state_reg == ST_LOAD) else $error("empty result");
`endif
endmodule
`default_nettype wire

/* rtl/pwc_vram.sv */
`timescale 1ns / 1ps
`default_nettype none
module pwc_vram
    import pwc_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [VTX_W-1:0]  wdata,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [VTX_W-1:0]  rdata
);
    logic [VTX_W-1:0] mem [2*BUF_VERTS];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

/* rtl/pwc_div.sv */
`timescale 1ns / 1ps
`default_nettype none
module pwc_div
    import pwc_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire div_req_t   req,
    output logic            done,
    output logic [30:0]     quot
);
    // restoring divide of (num<<30 + den/2) by den, one bit per cycle
    logic [63:0] rem_reg, rem_next;
    logic [32:0] den_reg;
    logic [30:0] q_reg, q_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic [63:0] trial;
    logic [63:0] dvd;

    always_comb
    begin
        dvd = ({32'd0, req.num} << 30) + {33'd0, req.den[31:1]};
        trial = rem_reg - ({31'd0, den_reg} << cnt_reg[4:0]);
        rem_next = rem_reg;
        q_next = q_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        if (req.start)
        begin
            rem_next = dvd;
            q_next = '0;
            cnt_next = 6'd30;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (rem_reg >= ({31'd0, den_reg} << cnt_reg[4:0]))
            begin
                rem_next = trial;
                q_next[cnt_reg[4:0]] = 1'b1;
            end
            if (cnt_reg == 6'd0)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                cnt_next = cnt_reg - 6'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        q_reg <= q_next;
        if (req.start)
        begin
            den_reg <= {1'b0, req.den};
        end
    end

    assign done = busy_reg && (cnt_reg == 6'd0);
    assign quot = q_next;
endmodule
`default_nettype wire
